>>> rtl/vhmm_pkg.sv
//------------------------------------------------------------------------------
// vhmm_pkg
// shared constants and command codes for the voxel histogram / min-max unit
//------------------------------------------------------------------------------
`default_nettype none

package vhmm_pkg;

  // default store geometry
  localparam int unsigned BIN_COUNT_DEFAULT   = 65536;
  localparam int unsigned COUNT_WIDTH_DEFAULT = 32;

  // fixed field widths
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned NARROW_W    = 8;
  localparam int unsigned RANGE_W     = 17;
  localparam int unsigned OUT_COUNT_W = 32;

  typedef enum logic [1:0] {
    CMD_ACCUM = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } command_e;

endpackage

`default_nettype wire

>>> rtl/voxel_histogram_minmax_unit.sv
//------------------------------------------------------------------------------
// voxel_histogram_minmax_unit
// histogram of unsigned voxel samples with running minimum and maximum
//------------------------------------------------------------------------------
// Each transfer on the input channel carries one command. Accumulate bumps the
// sample's bin (saturating at all ones) and widens the running range; a sample
// flagged last finalises the range, spreading a flat range by one on each side.
// Read returns one bin count; clear zeroes every bin and resets the range. Every
// command produces exactly one result transfer carrying the state after it.
// Bin counts live in a single-port synchronous memory: accumulate and read
// first read the bin, then accumulate writes it back and both give the
// result; an unused command code gives only the result, and clear sweeps the
// memory one bin per cycle. The same clearing pass runs after reset, with the
// input stalled; voxel_mode writes are taken during it. BIN_COUNT must be a
// power of two; bin indices wrap modulo BIN_COUNT. A result waiting on a
// stalled output does not block acceptance of the next command.
//------------------------------------------------------------------------------
`default_nettype none

module voxel_histogram_minmax_unit
  import vhmm_pkg::*;
#(
  parameter int unsigned BIN_COUNT   = BIN_COUNT_DEFAULT,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_data_i,
  // command channel
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [1:0]                command_i,
  input  wire logic [VALUE_W-1:0]        sample_value_i,
  input  wire logic [VALUE_W-1:0]        bin_index_i,
  input  wire logic                      last_sample_i,
  // result channel
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [OUT_COUNT_W-1:0]         bin_count_o,
  output logic signed [RANGE_W-1:0]      range_min_o,
  output logic [RANGE_W-1:0]             range_max_o,
  output logic                           range_final_o
);

  localparam int unsigned AW = $clog2(BIN_COUNT);
  localparam logic [AW-1:0] PtrLast = AW'(BIN_COUNT - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WAIT
  } state_e;

  state_e state_q, state_d;

  logic voxel_mode_q;

  // captured command
  command_e           cmd_q, cmd_d;
  logic [VALUE_W-1:0] samp_q, samp_d;
  logic               last_q, last_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic               clr_pend_q, clr_pend_d;
  logic [AW-1:0]      ptr_q, ptr_d;

  // range state
  logic signed [RANGE_W-1:0] lo_q, lo_d;
  logic [RANGE_W-1:0]        hi_q, hi_d;
  logic                      any_q, any_d;
  logic                      fin_q, fin_d;

  // result
  logic [OUT_COUNT_W-1:0]    res_cnt_q, res_cnt_d;
  logic                      load_out;
  logic                      out_valid_q;
  logic [OUT_COUNT_W-1:0]    bin_count_q;
  logic signed [RANGE_W-1:0] range_min_q;
  logic [RANGE_W-1:0]        range_max_q;
  logic                      range_final_q;

  // memory port
  logic                   mem_we;
  logic [AW-1:0]          mem_addr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [COUNT_WIDTH-1:0] mem_rdata;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [OUT_COUNT_W+COUNT_WIDTH-1:0] rd_ext;

  // input decode
  logic               in_fire;
  logic               out_free;
  logic [VALUE_W-1:0] idx_sel;
  logic [VALUE_W-1:0] idx_masked;
  logic [VALUE_W-1:0] samp_masked;
  logic [AW-1:0]      in_addr;

  // accumulate update
  logic signed [RANGE_W-1:0] v_s;
  logic signed [RANGE_W-1:0] lo_w, lo_n;
  logic [RANGE_W-1:0]        hi_w, hi_n;
  logic                      flat;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // 8-bit mode drops the upper sample / index byte
  assign idx_sel     = (command_i == CMD_READ) ? bin_index_i : sample_value_i;
  assign idx_masked  = voxel_mode_q ? idx_sel
                                    : {{(VALUE_W-NARROW_W){1'b0}}, idx_sel[NARROW_W-1:0]};
  assign samp_masked = voxel_mode_q ? sample_value_i
                                    : {{(VALUE_W-NARROW_W){1'b0}},
                                       sample_value_i[NARROW_W-1:0]};
  assign in_addr     = idx_masked[AW-1:0];

  // saturating increment and count widening / truncation to the output width
  assign cnt_inc = (mem_rdata == '1) ? mem_rdata : mem_rdata + COUNT_WIDTH'(1);
  assign rd_ext  = {{OUT_COUNT_W{1'b0}}, mem_rdata};

  // range widening, then flat-range spread on the last sample
  always_comb begin
    v_s = {1'b0, samp_q};
    if (!any_q) begin
      lo_w = v_s;
      hi_w = {1'b0, samp_q};
    end else begin
      lo_w = (v_s < lo_q) ? v_s : lo_q;
      hi_w = ({1'b0, samp_q} > hi_q) ? {1'b0, samp_q} : hi_q;
    end
    flat = ({lo_w[RANGE_W-1], lo_w} == {1'b0, hi_w});
    if (last_q && flat) begin
      lo_n = lo_w - RANGE_W'(1);
      hi_n = hi_w + RANGE_W'(1);
    end else begin
      lo_n = lo_w;
      hi_n = hi_w;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    samp_d     = samp_q;
    last_d     = last_q;
    addr_d     = addr_q;
    clr_pend_d = clr_pend_q;
    ptr_d      = ptr_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    any_d      = any_q;
    fin_d      = fin_q;
    res_cnt_d  = res_cnt_q;
    load_out   = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = in_addr;
    mem_wdata  = '0;

    case (state_q)
      ST_CLEAR: begin
        // sweep zeroes one bin per cycle
        mem_we   = 1'b1;
        mem_addr = ptr_q;
        if (ptr_q == PtrLast) begin
          ptr_d      = '0;
          clr_pend_d = 1'b0;
          state_d    = clr_pend_q ? ST_WAIT : ST_IDLE;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d     = command_e'(command_i);
          samp_d    = samp_masked;
          last_d    = last_sample_i;
          addr_d    = in_addr;
          res_cnt_d = '0;
          case (command_i)
            CMD_ACCUM, CMD_READ: begin
              state_d = ST_EXEC;
            end
            CMD_CLEAR: begin
              lo_d       = '1;
              hi_d       = '0;
              any_d      = 1'b0;
              fin_d      = 1'b0;
              clr_pend_d = 1'b1;
              state_d    = ST_CLEAR;
            end
            default: begin
              state_d = ST_WAIT;
            end
          endcase
        end
      end
      ST_EXEC: begin
        // read data for addr_q is on the memory output now
        mem_addr = addr_q;
        if (cmd_q == CMD_ACCUM) begin
          mem_we    = 1'b1;
          mem_wdata = cnt_inc;
          lo_d      = lo_n;
          hi_d      = hi_n;
          any_d     = 1'b1;
          fin_d     = fin_q || last_q;
        end else begin
          res_cnt_d = rd_ext[OUT_COUNT_W-1:0];
        end
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      voxel_mode_q  <= 1'b0;
      cmd_q         <= CMD_ACCUM;
      samp_q        <= '0;
      last_q        <= 1'b0;
      addr_q        <= '0;
      clr_pend_q    <= 1'b0;
      ptr_q         <= '0;
      lo_q          <= '1;
      hi_q          <= '0;
      any_q         <= 1'b0;
      fin_q         <= 1'b0;
      res_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
      bin_count_q   <= '0;
      range_min_q   <= '0;
      range_max_q   <= '0;
      range_final_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cmd_q      <= cmd_d;
      samp_q     <= samp_d;
      last_q     <= last_d;
      addr_q     <= addr_d;
      clr_pend_q <= clr_pend_d;
      ptr_q      <= ptr_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      any_q      <= any_d;
      fin_q      <= fin_d;
      res_cnt_q  <= res_cnt_d;
      if (cfg_we_i) begin
        voxel_mode_q <= cfg_data_i;
      end
      // output register, reloaded in the cycle it is taken
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
      if (load_out) begin
        bin_count_q   <= res_cnt_d;
        range_min_q   <= any_d ? lo_d : '0;
        range_max_q   <= any_d ? hi_d : '0;
        range_final_q <= fin_d;
      end
    end
  end

  vhmm_bin_ram #(
    .DEPTH (BIN_COUNT),
    .WIDTH (COUNT_WIDTH)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign bin_count_o   = bin_count_q;
  assign range_min_o   = range_min_q;
  assign range_max_o   = range_max_q;
  assign range_final_o = range_final_q;

  // no command is taken while the clear sweep is partway through
  a_sweep_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ptr_q != '0) |-> in_stall_o)
    else $error("command accepted during clear sweep");

  // an accepted command always moves the unit out of idle in the next cycle
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE))
    else $error("command accepted without execution");

  // a finalised range implies at least one sample seen
  a_final_needs_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> any_q)
    else $error("range finalised with no sample");

  // tracked minimum never exceeds tracked maximum
  a_range_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_q |-> ($signed({lo_q[RANGE_W-1], lo_q}) <= $signed({1'b0, hi_q})))
    else $error("range minimum above maximum");

endmodule

`default_nettype wire

>>> rtl/vhmm_bin_ram.sv
//------------------------------------------------------------------------------
// vhmm_bin_ram
// single-port bin count memory, registered read data
//------------------------------------------------------------------------------
`default_nettype none

module vhmm_bin_ram
  import vhmm_pkg::*;
#(
  parameter int unsigned DEPTH = BIN_COUNT_DEFAULT,
  parameter int unsigned WIDTH = COUNT_WIDTH_DEFAULT,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write has priority, read otherwise
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
